// ----- rtl/esd_pkg.sv -----
// Shared types, character constants and helper functions for the escape sequence decoder.
package esd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_A      = 8'h61;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
  localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [8:0] code;
    logic [2:0] len;
    logic       bad;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    one;
    logic    two;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic result_t make_result(logic [8:0] code, logic [2:0] len,
                                          logic bad, logic last);
    result_t r;
    r.code = code;
    r.len  = len;
    r.bad  = bad;
    r.last = last;
    return r;
  endfunction

  // Returns {valid, value} for a hexadecimal digit character.
  function automatic logic [4:0] hex_nibble(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h37);
  endfunction

  // Returns {valid, control code} for the single-letter escapes.
  function automatic logic [4:0] letter_code(logic [7:0] b);
    logic [4:0] r;
    unique case (b)
      CH_N:    r = {1'b1, 4'd10};
      CH_T:    r = {1'b1, 4'd9};
      CH_R:    r = {1'b1, 4'd13};
      CH_B:    r = {1'b1, 4'd8};
      CH_F:    r = {1'b1, 4'd12};
      CH_V:    r = {1'b1, 4'd11};
      CH_A:    r = {1'b1, 4'd7};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/esd_decode.sv -----
// Escape decoding state machine: one byte per transfer, up to two results.
module esd_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           escape_enable,
  output esd_pkg::push_t push,
  output logic           idle
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_BSLASH = 2'd1;
  localparam logic [1:0] MODE_OCT    = 2'd2;
  localparam logic [1:0] MODE_HEX    = 2'd3;

  logic [1:0] mode;
  logic [1:0] count;
  logic [8:0] acc;
  logic [1:0] mode_next;
  logic [1:0] count_next;
  logic [8:0] acc_next;

  esd_pkg::push_t  step;
  esd_pkg::result_t fresh_res;
  logic            fresh_opens;
  logic            is_bslash;
  logic [4:0]      hex;
  logic [4:0]      letter;
  logic            oct_ok;
  logic [1:0]      cnt_inc;
  logic [8:0]      oct_acc;
  logic [8:0]      hex_acc;

  assign hex      = esd_pkg::hex_nibble(in_byte);
  assign letter   = esd_pkg::letter_code(in_byte);
  assign oct_ok   = esd_pkg::is_octal(in_byte);
  assign cnt_inc  = count + 2'd1;
  assign oct_acc  = {acc[5:0], in_byte[2:0]};
  assign hex_acc  = {acc[4:0], hex[3:0]};

  assign is_bslash   = escape_enable && (in_byte == esd_pkg::CH_BSLASH);
  assign fresh_opens = is_bslash && !in_last;
  assign fresh_res   = is_bslash ? esd_pkg::make_result(9'd0, 3'd1, 1'b1, 1'b1)
                                 : esd_pkg::make_result({1'b0, in_byte}, 3'd1, 1'b0, in_last);

  always_comb begin
    mode_next  = mode;
    count_next = count;
    acc_next   = acc;
    step       = '0;
    unique case (mode)
      MODE_IDLE: begin
        step.one  = !fresh_opens;
        step.r0   = fresh_res;
        mode_next = fresh_opens ? MODE_BSLASH : MODE_IDLE;
      end
      MODE_BSLASH: begin
        mode_next  = MODE_IDLE;
        count_next = 2'd0;
        acc_next   = 9'd0;
        if (letter[4]) begin
          step.one = 1'b1;
          step.r0  = esd_pkg::make_result({5'd0, letter[3:0]}, 3'd2, 1'b0, in_last);
        end else if (oct_ok) begin
          if (in_last) begin
            step.one = 1'b1;
            step.r0  = esd_pkg::make_result({6'd0, in_byte[2:0]}, 3'd2, 1'b0, 1'b1);
          end else begin
            mode_next  = MODE_OCT;
            count_next = 2'd1;
            acc_next   = {6'd0, in_byte[2:0]};
          end
        end else if (in_byte == esd_pkg::CH_X) begin
          if (in_last) begin
            step.one = 1'b1;
            step.r0  = esd_pkg::make_result(9'd0, 3'd2, 1'b1, 1'b1);
          end else begin
            mode_next = MODE_HEX;
          end
        end else begin
          step.one = 1'b1;
          step.r0  = esd_pkg::make_result({1'b0, in_byte}, 3'd2, 1'b0, in_last);
        end
      end
      MODE_OCT: begin
        if (oct_ok) begin
          if (cnt_inc == esd_pkg::OCT_MAX_DIGITS || in_last) begin
            step.one   = 1'b1;
            step.r0    = esd_pkg::make_result(oct_acc, {1'b0, cnt_inc} + 3'd1, 1'b0, in_last);
            mode_next  = MODE_IDLE;
            count_next = 2'd0;
            acc_next   = 9'd0;
          end else begin
            count_next = cnt_inc;
            acc_next   = oct_acc;
          end
        end else begin
          step.one   = 1'b1;
          step.r0    = esd_pkg::make_result(acc, {1'b0, count} + 3'd1, 1'b0, 1'b0);
          step.two   = !fresh_opens;
          step.r1    = fresh_res;
          mode_next  = fresh_opens ? MODE_BSLASH : MODE_IDLE;
          count_next = 2'd0;
          acc_next   = 9'd0;
        end
      end
      MODE_HEX: begin
        if (hex[4]) begin
          if (cnt_inc == esd_pkg::HEX_MAX_DIGITS || in_last) begin
            step.one   = 1'b1;
            step.r0    = esd_pkg::make_result(hex_acc, {1'b0, cnt_inc} + 3'd2, 1'b0, in_last);
            mode_next  = MODE_IDLE;
            count_next = 2'd0;
            acc_next   = 9'd0;
          end else begin
            count_next = cnt_inc;
            acc_next   = hex_acc;
          end
        end else begin
          step.one = 1'b1;
          if (count == 2'd0) begin
            step.r0 = esd_pkg::make_result(9'd0, 3'd2, 1'b1, 1'b0);
          end else begin
            step.r0 = esd_pkg::make_result(acc, {1'b0, count} + 3'd2, 1'b0, 1'b0);
          end
          step.two   = !fresh_opens;
          step.r1    = fresh_res;
          mode_next  = fresh_opens ? MODE_BSLASH : MODE_IDLE;
          count_next = 2'd0;
          acc_next   = 9'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      count <= 2'd0;
      acc   <= 9'd0;
    end else if (take) begin
      mode  <= mode_next;
      count <= count_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    push     = step;
    push.one = step.one && take;
    push.two = step.two && take;
  end

  assign idle = (mode == MODE_IDLE);

endmodule

// ----- rtl/esd_outq.sv -----
// Four-entry result queue that takes up to two results per cycle and releases one.
module esd_outq (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::push_t   push,
  input  logic             pop,
  output logic             room,
  output logic             not_empty,
  output esd_pkg::result_t head
);

  esd_pkg::result_t q [esd_pkg::QUEUE_DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [1:0] push_n;

  assign push_n     = {1'b0, push.one} + {1'b0, push.two};
  assign count_next = count + {1'b0, push_n} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push.one) begin
      q[wptr] <= push.r0;
    end
    if (push.two) begin
      q[wptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + push_n;
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

  assign room      = (count <= 3'd2);
  assign not_empty = (count != 3'd0);
  assign head      = q[rptr];

endmodule

// ----- rtl/escape_sequence_decoder_core.sv -----
// Top level of the streaming escape sequence decoder with its result queue.
// A decoded result is written into the four-entry queue when the byte that completes it
// is transferred and is offered once the results ahead of it have left. One byte is
// accepted per cycle while the queue holds at most two results; results leave at one
// per cycle while out_ready is high; a byte ending a digit run may yield two results.
// Synchronous reset empties the queue, returns to plain text and sets escape_enable.
module escape_sequence_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] char_code,
  output logic [2:0] source_length,
  output logic       bad_escape,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic             escape_enable;
  logic             take;
  logic             pop;
  logic             dec_idle;
  esd_pkg::push_t   push;
  esd_pkg::result_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      escape_enable <= cfg_data;
    end
  end

  assign take = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  esd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .escape_enable (escape_enable),
    .push          (push),
    .idle          (dec_idle)
  );

  esd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room      (in_ready),
    .not_empty (out_valid),
    .head      (head)
  );

  assign char_code     = head.code;
  assign source_length = head.len;
  assign bad_escape    = head.bad;
  assign out_last      = head.last;

  // A second result is only ever produced together with a first one.
  a_two_needs_one: assert property (@(posedge clk) disable iff (rst)
    push.two |-> push.one)
    else $error("second result pushed without a first");

  // An empty queue always has room for a new byte.
  a_empty_has_room: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the queue is empty");

  // The final byte of a string always yields a result and closes any escape.
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (take && in_last) |-> push.one)
    else $error("final byte produced no result");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (take && in_last) |=> dec_idle)
    else $error("escape left open after the final byte");

endmodule
